// ===== src/sha_pkg.sv =====
// ============================================================================
// sha_pkg: shared types and constants for the SHA-256 byte stream hasher
// Round constants, initial hash values and the front/back queue entry.
// ============================================================================
`default_nettype none
package sha_pkg;

   // queue entry kinds
   typedef enum logic [1:0] {
      OP_BYTE  = 2'd0,   // one message byte
      OP_FINAL = 2'd1    // end of message, pad and emit
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] data;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'd0,
      ST_LOAD   = 3'd1,
      ST_ROUND  = 3'd2,
      ST_FOLD   = 3'd3,
      ST_PAD    = 3'd4,
      ST_EMIT   = 3'd5
   } state_type;

   localparam logic [7:0] PAD_BYTE = 8'h80;
   localparam logic [5:0] LEN_POS  = 6'd56;

   function automatic logic [31:0] round_k(input logic [5:0] i);
      logic [31:0] k [64];
      k = '{
         32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
         32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
         32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
         32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
         32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
         32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
         32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
         32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
         32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
         32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
         32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
      return k[i];
   endfunction

   function automatic logic [31:0] init_h(input logic [2:0] i);
      logic [31:0] h [8];
      h = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
            32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
      return h[i];
   endfunction

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

endpackage
`default_nettype wire

// ===== src/sha_if.sv =====
// ============================================================================
// sha_req_if / sha_rsp_if: valid/ready channels
// Request channel carries bytes and the end flag; response carries digest words.
// ============================================================================
`default_nettype none
interface sha_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       has_byte;
   logic       end_of_message;
   modport source (output valid, data_byte, has_byte, end_of_message, input ready);
   modport sink   (input valid, data_byte, has_byte, end_of_message, output ready);
endinterface

interface sha_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last_word;
   modport source (output valid, digest_word, word_index, last_word, input ready);
   modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface
`default_nettype wire

// ===== src/sha_ram.sv =====
// ============================================================================
// sha_ram: generic simple dual port RAM with registered read
// One write and one read per cycle, at separate addresses.
// ============================================================================
`default_nettype none
module sha_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ===== src/sha_front.sv =====
// ============================================================================
// sha_front: request intake and classification
// Splits each request into byte and final entries, pushed to a 2-entry queue.
// ============================================================================
`default_nettype none
module sha_front
   import sha_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   sha_req_if.sink    req,
   output entry_type  q_data,
   output logic       q_valid,
   input  wire logic  q_pop
);
   entry_type  buf_ff [2];
   entry_type  buf_in [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       pend_ff, pend_in;   // final still owed from a byte+end request
   logic       push;
   entry_type  push_e;

   assign q_valid = cnt_ff != 2'd0;
   assign q_data  = buf_ff[0];
   // take a request only with room for both entries it may make
   assign req.ready = !pend_ff && cnt_ff == 2'd0;

   // classify and queue
   always_comb begin
      pend_in = pend_ff;
      push    = 1'b0;
      push_e  = '{op: OP_FINAL, data: 8'd0};
      if (pend_ff && !(cnt_ff == 2'd2 && !q_pop)) begin
         push    = 1'b1;
         pend_in = 1'b0;
      end else if (req.valid && req.ready) begin
         if (req.has_byte) begin
            push    = 1'b1;
            push_e  = '{op: OP_BYTE, data: req.data_byte};
            pend_in = req.end_of_message;
         end else if (req.end_of_message) begin
            push = 1'b1;
         end
      end
      buf_in = buf_ff;
      cnt_in = cnt_ff;
      if (q_pop) begin
         buf_in[0] = buf_ff[1];
         cnt_in    = cnt_ff - 2'd1;
      end
      if (push) begin
         buf_in[cnt_in[0]] = push_e;
         cnt_in            = cnt_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= 2'd0;
         pend_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         pend_ff <= pend_in;
      end
      buf_ff <= buf_in;
   end
endmodule
`default_nettype wire

// ===== src/sha_back.sv =====
// ============================================================================
// sha_back: block buffer, padding and 64-round compression
// Writes bytes to the block RAM, compresses full blocks, emits the digest.
// ============================================================================
`default_nettype none
module sha_back
   import sha_pkg::*;
#(
   parameter int COUNT_BITS = 61
) (
   input  wire logic  clock,
   input  wire logic  reset,
   input  entry_type  q_data,
   input  wire logic  q_valid,
   output logic       q_pop,
   sha_rsp_if.source  rsp
);
   state_type state_ff, state_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [31:0] h_ff [8];
   logic [31:0] h_in [8];
   logic [31:0] v_ff [8];
   logic [31:0] v_in [8];
   logic [31:0] w_ff [16];
   logic [31:0] w_in [16];
   logic [6:0]  idx_ff, idx_in;     // load address / round number
   logic [5:0]  pos_ff, pos_in;     // pad position
   logic        fin_ff, fin_in;     // padding phase of a message end
   logic        len_ff, len_in;     // current pad block ends with the length
   logic [63:0] bits_ff, bits_in;   // bit length, shifted out MSB first
   logic [2:0]  out_ff, out_in;
   logic        ov_ff, ov_in;
   logic [31:0] od_ff, od_in;

   logic        wr_en;
   logic [5:0]  wr_addr, rd_addr;
   logic [7:0]  wr_data, rd_data;

   sha_ram #(.WIDTH(8), .DEPTH(64)) u_ram (
      .clock, .wr_en, .wr_addr, .wr_data, .rd_addr, .rd_data
   );

   logic [31:0] s0, s1, wnew, t1, t2, e, a, ch, maj;

   assign rsp.valid       = ov_ff;
   assign rsp.digest_word = od_ff;
   assign rsp.word_index  = out_ff;
   assign rsp.last_word   = out_ff == 3'd7;

   // round datapath
   always_comb begin
      s0   = rotr(w_ff[1], 7) ^ rotr(w_ff[1], 18) ^ (w_ff[1] >> 3);
      s1   = rotr(w_ff[14], 17) ^ rotr(w_ff[14], 19) ^ (w_ff[14] >> 10);
      wnew = s1 + w_ff[9] + s0 + w_ff[0];
      e    = v_ff[4];
      a    = v_ff[0];
      ch   = (e & v_ff[5]) ^ (~e & v_ff[6]);
      maj  = (a & v_ff[1]) ^ (a & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
      t1   = v_ff[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ch
             + round_k(idx_ff[5:0]) + w_ff[0];
      t2   = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + maj;
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      h_in = h_ff; v_in = v_ff; w_in = w_ff;
      idx_in = idx_ff; pos_in = pos_ff; fin_in = fin_ff; len_in = len_ff;
      bits_in = bits_ff;
      out_in = out_ff; ov_in = ov_ff; od_in = od_ff;
      q_pop = 1'b0;
      wr_en = 1'b0; wr_addr = pos_ff; wr_data = 8'd0;
      rd_addr = idx_ff[5:0];
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               if (q_data.op == OP_BYTE) begin
                  wr_en    = 1'b1;
                  wr_addr  = count_ff[5:0];
                  wr_data  = q_data.data;
                  count_in = count_ff + COUNT_BITS'(1);
                  fin_in   = 1'b0;
                  if (count_ff[5:0] == 6'd63) begin
                     idx_in   = 7'd0;
                     state_in = ST_LOAD;
                  end
               end else begin
                  // 0x80 marker; length fits in this block below byte 56
                  bits_in  = 64'(count_ff) << 3;
                  wr_en    = 1'b1;
                  wr_addr  = count_ff[5:0];
                  wr_data  = PAD_BYTE;
                  fin_in   = 1'b1;
                  len_in   = count_ff[5:0] < LEN_POS;
                  count_in = '0;
                  if (count_ff[5:0] == 6'd63) begin
                     idx_in   = 7'd0;
                     state_in = ST_LOAD;
                  end else begin
                     pos_in   = count_ff[5:0] + 6'd1;
                     state_in = ST_PAD;
                  end
               end
            end
         end
         // zeros up to byte 56, then the length (zeros to the end if it does not fit); compress when full
         ST_PAD: begin
            wr_en = 1'b1;
            if (len_ff && pos_ff >= LEN_POS) begin
               wr_data = bits_ff[63:56];
               bits_in = {bits_ff[55:0], 8'd0};
            end
            pos_in = pos_ff + 6'd1;
            if (pos_ff == 6'd63) begin
               idx_in   = 7'd0;
               state_in = ST_LOAD;
            end
         end
         // shift 64 bytes into the schedule window (RAM read is registered)
         ST_LOAD: begin
            if (idx_ff != 7'd0) begin
               if (idx_ff[1:0] == 2'd1) begin
                  for (int i = 0; i < 15; i++) w_in[i] = w_ff[i + 1];
                  w_in[15] = {24'd0, rd_data};
               end else begin
                  w_in[15] = {w_ff[15][23:0], rd_data};
               end
            end
            idx_in = idx_ff + 7'd1;
            if (idx_ff == 7'd64) begin
               v_in     = h_ff;
               idx_in   = 7'd0;
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            for (int i = 0; i < 15; i++) w_in[i] = w_ff[i + 1];
            w_in[15] = wnew;
            v_in[7] = v_ff[6]; v_in[6] = v_ff[5]; v_in[5] = e;
            v_in[4] = v_ff[3] + t1; v_in[3] = v_ff[2]; v_in[2] = v_ff[1];
            v_in[1] = a; v_in[0] = t1 + t2;
            idx_in = idx_ff + 7'd1;
            if (idx_ff == 7'd63) state_in = ST_FOLD;
         end
         // add into the chain; then emit, pad the length block, or go idle
         ST_FOLD: begin
            for (int i = 0; i < 8; i++) h_in[i] = h_ff[i] + v_ff[i];
            if (fin_ff && len_ff) begin
               out_in   = 3'd0;
               ov_in    = 1'b1;
               od_in    = h_ff[0] + v_ff[0];
               state_in = ST_EMIT;
            end else if (fin_ff) begin
               pos_in   = 6'd0;
               len_in   = 1'b1;
               state_in = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (rsp.ready) begin
               if (out_ff == 3'd7) begin
                  ov_in  = 1'b0;
                  fin_in = 1'b0;
                  for (int i = 0; i < 8; i++) h_in[i] = init_h(3'(i));
                  state_in = ST_IDLE;
               end else begin
                  out_in = out_ff + 3'd1;
                  od_in  = h_ff[out_ff + 3'd1];
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         ov_ff    <= 1'b0;
         fin_ff   <= 1'b0;
         len_ff   <= 1'b0;
         out_ff   <= 3'd0;
         for (int i = 0; i < 8; i++) h_ff[i] <= init_h(3'(i));
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ov_ff    <= ov_in;
         fin_ff   <= fin_in;
         len_ff   <= len_in;
         out_ff   <= out_in;
         h_ff     <= h_in;
      end
      v_ff    <= v_in;
      w_ff    <= w_in;
      idx_ff  <= idx_in;
      pos_ff  <= pos_in;
      bits_ff <= bits_in;
      od_ff   <= od_in;
   end
endmodule
`default_nettype wire

// ===== src/sha256_byte_stream_hasher_core.sv =====
// ============================================================================
// sha256_byte_stream_hasher_core: SHA-256 over a byte stream
// Front intake queue feeding a sequential block compressor.
// ============================================================================
//  channel | dir | fields
//  req     | in  | data_byte[7:0], has_byte, end_of_message
//  rsp     | out | digest_word[31:0], word_index[2:0], last_word
// Bytes fill the block RAM; a full block is loaded, run for 64 rounds, folded.
// The end of message pads byte by byte, compresses one or two blocks, then
// emits eight words, one per accepted rsp.
// Reset is synchronous; the hash restarts from the initial values after emit.
// ============================================================================
`default_nettype none
module sha256_byte_stream_hasher_core
   import sha_pkg::*;
#(
   parameter int COUNT_BITS = 61
) (
   input wire logic  clock,
   input wire logic  reset,
   sha_req_if.sink   req,
   sha_rsp_if.source rsp
);
   entry_type q_data;
   logic      q_valid, q_pop;

   sha_front u_front (.clock, .reset, .req, .q_data, .q_valid, .q_pop);

   sha_back #(.COUNT_BITS(COUNT_BITS)) u_back (
      .clock, .reset, .q_data, .q_valid, .q_pop, .rsp
   );
endmodule
`default_nettype wire
